// ----- design/visibility_table_merge_elect_defines.svh -----
// Assertion macros shared by the visibility table checker.
`ifndef VISIBILITY_TABLE_MERGE_ELECT_DEFINES_SVH
`define VISIBILITY_TABLE_MERGE_ELECT_DEFINES_SVH

// An implication that must hold in the same cycle.
`define VTME_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("visibility table check failed");

// An implication whose consequence must hold in the next cycle.
`define VTME_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("visibility table check failed");

`endif

// ----- design/vtme_pkg.sv -----
// Types, codes and helper functions of the visibility table block.
package vtme_pkg;

   // Command codes.
   localparam logic [1:0] CMD_MERGE  = 2'd0;
   localparam logic [1:0] CMD_REMOVE = 2'd1;
   localparam logic [1:0] CMD_ELECT  = 2'd2;
   localparam logic [1:0] CMD_INIT   = 2'd3;

   // Register indexes of the configuration port.
   localparam logic CSR_LOCAL_ID   = 1'b0;
   localparam logic CSR_NODE_COUNT = 1'b1;

   localparam int ID_W    = 4;
   localparam int COUNT_W = 5;
   localparam int VIEW_W  = 16;

   // Request beat.
   typedef struct packed {
      logic [1:0]         cmd;
      logic [ID_W-1:0]    sender_id;
      logic [ID_W-1:0]    entry_index;
      logic               in_is_new;
      logic [3:0]         in_degree;
      logic [VIEW_W-1:0]  in_state;
      logic               last_entry;
      logic [3:0]         clear_bit;
      logic               ignore_self;
   } req_type;

   // Response beat.
   typedef struct packed {
      logic [ID_W-1:0]    leader_id;
      logic [COUNT_W-1:0] leader_count;
   } rsp_type;

   // One table entry as stored in memory.
   typedef struct packed {
      logic              is_new;
      logic [3:0]        degree;
      logic [VIEW_W-1:0] view;
   } entry_type;

   localparam entry_type ENTRY_RESET = '{is_new: 1'b1, degree: 4'd0, view: '0};

   // Static configuration seen by the sequencer.
   typedef struct packed {
      logic [ID_W-1:0]    local_id;
      logic [COUNT_W-1:0] in_use;
      logic               local_in_table;
   } cfg_type;

   // Access request from the sequencer to the table memory.
   typedef struct packed {
      logic [ID_W-1:0]    rd_addr;
      logic               wr_en;
      logic [ID_W-1:0]    wr_addr;
      entry_type          wr_data;
      logic               clr_en;
      logic [COUNT_W-1:0] clr_count;
   } tbl_req_type;

   // Number of set bits in a 16-bit mask.
   function automatic logic [COUNT_W-1:0] popcount16(input logic [VIEW_W-1:0] value);
      logic [VIEW_W-1:0] v;
      logic [VIEW_W-1:0] prod;
      begin
         v    = value - ((value >> 1) & 16'h5555);
         v    = (v & 16'h3333) + ((v >> 2) & 16'h3333);
         v    = (v + (v >> 4)) & 16'h0F0F;
         prod = v * 16'h0101;
         return prod[12:8];
      end
   endfunction

endpackage

// ----- design/vtme_table.sv -----
// Table memory with per-entry valid bits and registered read.
module vtme_table #(
   parameter int MAX_NODES = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  vtme_pkg::tbl_req_type tbl_req,
   output vtme_pkg::entry_type   rd_data
);

   localparam int IDX_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

   vtme_pkg::entry_type entry_mem_ff [MAX_NODES];
   vtme_pkg::entry_type rd_data_ff;
   logic                rd_valid_ff;
   logic [MAX_NODES-1:0] valid_ff;
   logic [MAX_NODES-1:0] valid_in;

   // An entry turns valid when written and invalid when init clears it.
   always_comb begin
      valid_in = valid_ff;
      if (tbl_req.clr_en) begin
         for (int i = 0; i < MAX_NODES; i++) begin
            if (vtme_pkg::COUNT_W'(i) < tbl_req.clr_count) begin
               valid_in[i] = 1'b0;
            end
         end
      end
      if (tbl_req.wr_en) begin
         valid_in[tbl_req.wr_addr[IDX_W-1:0]] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Memory write port.
   always_ff @(posedge clock) begin
      if (tbl_req.wr_en) begin
         entry_mem_ff[tbl_req.wr_addr[IDX_W-1:0]] <= tbl_req.wr_data;
      end
   end

   // Memory read port, data registered together with its valid bit.
   always_ff @(posedge clock) begin
      rd_data_ff  <= entry_mem_ff[tbl_req.rd_addr[IDX_W-1:0]];
      rd_valid_ff <= valid_ff[tbl_req.rd_addr[IDX_W-1:0]];
   end

   // An entry never written since reset, or since init last cleared it, reads as the reset value.
   assign rd_data = rd_valid_ff ? rd_data_ff : vtme_pkg::ENTRY_RESET;

endmodule

// ----- design/vtme_ctrl.sv -----
// Command sequencer: read-modify-write of table entries, election sweep, response register.
module vtme_ctrl #(
   parameter int MAX_NODES = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  vtme_pkg::req_type     req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output vtme_pkg::rsp_type     rsp_data,
   input  vtme_pkg::cfg_type     cfg,
   output vtme_pkg::tbl_req_type tbl_req,
   input  vtme_pkg::entry_type   tbl_rd_data
);

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_ENTRY_RD = 3'd1;
   localparam logic [2:0] ST_ENTRY_WR = 3'd2;
   localparam logic [2:0] ST_LOCAL_RD = 3'd3;
   localparam logic [2:0] ST_LOCAL_WR = 3'd4;
   localparam logic [2:0] ST_SWEEP    = 3'd5;
   localparam logic [2:0] ST_INIT     = 3'd6;
   localparam logic [2:0] ST_DONE     = 3'd7;

   localparam logic [vtme_pkg::COUNT_W-1:0] TABLE_SIZE = vtme_pkg::COUNT_W'(MAX_NODES);

   logic [2:0]                     state_ff, state_in;
   vtme_pkg::req_type              item_ff, item_in;
   logic [vtme_pkg::COUNT_W-1:0]   sweep_addr_ff, sweep_addr_in;
   logic                           cmp_valid_ff, cmp_valid_in;
   logic [vtme_pkg::ID_W-1:0]      cmp_idx_ff, cmp_idx_in;
   logic [vtme_pkg::ID_W-1:0]      leader_ff, leader_in;
   logic [vtme_pkg::COUNT_W-1:0]   best_ff, best_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   vtme_pkg::rsp_type              rsp_data_ff, rsp_data_in;

   logic                           idx_in_table;
   logic                           local_upd;
   logic                           merge_ok;
   logic                           bump;
   logic [3:0]                     deg_next;
   logic                           sweep_more;
   logic [vtme_pkg::COUNT_W-1:0]   popcnt;

   // Decisions on the incoming or latched item and the entry just read.
   assign idx_in_table = {1'b0, req_data.entry_index} < TABLE_SIZE;
   assign local_upd    = item_ff.last_entry && (item_ff.sender_id != cfg.local_id) &&
                         cfg.local_in_table;
   assign merge_ok     = ({1'b0, item_ff.entry_index} < cfg.in_use) &&
                         (item_ff.entry_index != cfg.local_id) && !item_ff.in_is_new &&
                         (item_ff.in_degree <= tbl_rd_data.degree);
   assign bump         = tbl_rd_data.is_new || (item_ff.in_degree < tbl_rd_data.degree);
   assign deg_next     = (bump && (item_ff.in_degree != 4'hF)) ? item_ff.in_degree + 4'd1
                                                               : item_ff.in_degree;
   assign sweep_more   = sweep_addr_ff < cfg.in_use;
   assign popcnt       = vtme_pkg::popcount16(tbl_rd_data.view);

   // Next-state and datapath logic.
   always_comb begin
      state_in      = state_ff;
      item_in       = item_ff;
      sweep_addr_in = sweep_addr_ff;
      cmp_valid_in  = 1'b0;
      cmp_idx_in    = cmp_idx_ff;
      leader_in     = leader_ff;
      best_in       = best_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      tbl_req       = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               item_in       = req_data;
               leader_in     = '0;
               best_in       = '0;
               sweep_addr_in = '0;
               unique case (req_data.cmd)
                  vtme_pkg::CMD_MERGE: begin
                     state_in = (req_data.sender_id != cfg.local_id) ? ST_ENTRY_RD : ST_DONE;
                  end
                  vtme_pkg::CMD_REMOVE: begin
                     state_in = idx_in_table ? ST_ENTRY_RD : ST_DONE;
                  end
                  vtme_pkg::CMD_ELECT: begin
                     state_in = ST_SWEEP;
                  end
                  vtme_pkg::CMD_INIT: begin
                     state_in = ST_INIT;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_ENTRY_RD: begin
            tbl_req.rd_addr = item_ff.entry_index;
            state_in        = ST_ENTRY_WR;
         end
         ST_ENTRY_WR: begin
            tbl_req.wr_addr = item_ff.entry_index;
            if (item_ff.cmd == vtme_pkg::CMD_MERGE) begin
               tbl_req.wr_en   = merge_ok;
               tbl_req.wr_data = '{is_new: 1'b0, degree: deg_next, view: item_ff.in_state};
               state_in        = local_upd ? ST_LOCAL_RD : ST_DONE;
            end else begin
               tbl_req.wr_en   = 1'b1;
               tbl_req.wr_data = tbl_rd_data;
               tbl_req.wr_data.view = tbl_rd_data.view & ~(16'h0001 << item_ff.clear_bit);
               state_in        = ST_DONE;
            end
         end
         ST_INIT: begin
            tbl_req.clr_en    = 1'b1;
            tbl_req.clr_count = cfg.in_use;
            state_in          = cfg.local_in_table ? ST_LOCAL_RD : ST_DONE;
         end
         ST_LOCAL_RD: begin
            tbl_req.rd_addr = cfg.local_id;
            state_in        = ST_LOCAL_WR;
         end
         ST_LOCAL_WR: begin
            tbl_req.wr_en   = 1'b1;
            tbl_req.wr_addr = cfg.local_id;
            tbl_req.wr_data = tbl_rd_data;
            if (item_ff.cmd == vtme_pkg::CMD_MERGE) begin
               tbl_req.wr_data.is_new = 1'b0;
               tbl_req.wr_data.view   = tbl_rd_data.view | (16'h0001 << item_ff.sender_id);
            end else begin
               tbl_req.wr_data.view   = 16'h0001 << cfg.local_id;
            end
            state_in = ST_DONE;
         end
         ST_SWEEP: begin
            // Issue one read a cycle; compare the entry read in the cycle before.
            if (sweep_more) begin
               tbl_req.rd_addr = sweep_addr_ff[vtme_pkg::ID_W-1:0];
               cmp_valid_in    = 1'b1;
               cmp_idx_in      = sweep_addr_ff[vtme_pkg::ID_W-1:0];
               sweep_addr_in   = sweep_addr_ff + vtme_pkg::COUNT_W'(1);
            end
            if (cmp_valid_ff && !(item_ff.ignore_self && (cmp_idx_ff == cfg.local_id)) &&
                (popcnt > best_ff)) begin
               best_in   = popcnt;
               leader_in = cmp_idx_ff;
            end
            if (!sweep_more && !cmp_valid_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{leader_id: leader_ff, leader_count: best_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      item_ff       <= item_in;
      sweep_addr_ff <= sweep_addr_in;
      cmp_idx_ff    <= cmp_idx_in;
      leader_ff     <= leader_in;
      best_ff       <= best_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- design/visibility_table_merge_elect.sv -----
// Visibility table with merge, remove, init and leader election: top level.
//
// Request channel (req_): one command beat per item, accepted when req_valid is
// high and req_stall is low. Response channel (rsp_): exactly one beat per
// command; leader_id and leader_count are zero for all commands but elect.
// Configuration port (csr_): index 0 local_id, index 1 node_count; always ready.
// The user must write it only while no command is in flight; the block does not enforce this.
// The table lives in one memory with a single read port, so commands read
// entries one at a time and the elect sweep issues one read per cycle; one
// command is in flight at a time, and the next request is taken in the cycle
// after the previous response is registered.
// A registered response waits while rsp_stall is high; the block still accepts
// and processes the next command and holds it at the end until the register
// frees up.
// Reset clears all valid bits at once, so every entry reads as new, degree
// zero, empty mask; local_id returns to 0 and node_count to 16.
module visibility_table_merge_elect #(
   parameter int MAX_NODES = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  vtme_pkg::req_type             req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output vtme_pkg::rsp_type             rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic                          csr_index,
   input  logic [vtme_pkg::COUNT_W-1:0]  csr_data
);

   localparam logic [vtme_pkg::COUNT_W-1:0] TABLE_SIZE = vtme_pkg::COUNT_W'(MAX_NODES);

   logic [vtme_pkg::ID_W-1:0]    local_id_ff;
   logic [vtme_pkg::COUNT_W-1:0] node_count_ff;
   vtme_pkg::cfg_type            cfg;
   vtme_pkg::tbl_req_type        tbl_req;
   vtme_pkg::entry_type          tbl_rd_data;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         local_id_ff   <= '0;
         node_count_ff <= vtme_pkg::COUNT_W'(16);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            vtme_pkg::CSR_LOCAL_ID:   local_id_ff   <= csr_data[vtme_pkg::ID_W-1:0];
            vtme_pkg::CSR_NODE_COUNT: node_count_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   // Entries in use are capped at the table size.
   always_comb begin
      cfg.local_id       = local_id_ff;
      cfg.in_use         = (node_count_ff > TABLE_SIZE) ? TABLE_SIZE : node_count_ff;
      cfg.local_in_table = {1'b0, local_id_ff} < TABLE_SIZE;
   end

   vtme_ctrl #(
      .MAX_NODES (MAX_NODES)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .cfg         (cfg),
      .tbl_req     (tbl_req),
      .tbl_rd_data (tbl_rd_data)
   );

   vtme_table #(
      .MAX_NODES (MAX_NODES)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .tbl_req (tbl_req),
      .rd_data (tbl_rd_data)
   );

endmodule

// ----- design/vtme_checker.sv -----
// Port-level checker of the visibility table block and its bind.
`include "visibility_table_merge_elect_defines.svh"

module vtme_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input vtme_pkg::rsp_type rsp_data
);

   // A stalled response beat holds its payload.
   `VTME_ASSERT_NEXT(rsp_hold_a, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   // One command at a time: an accepted request closes the request side.
   `VTME_ASSERT_NEXT(one_in_flight_a, clock, reset, req_valid && !req_stall, req_stall)

   // An empty count always comes with leader zero.
   `VTME_ASSERT_IMPLY(empty_leader_a, clock, reset, rsp_valid && (rsp_data.leader_count == 5'd0), rsp_data.leader_id == 4'd0)

   // A popcount of a 16-bit mask never exceeds sixteen.
   `VTME_ASSERT_IMPLY(count_range_a, clock, reset, rsp_valid, rsp_data.leader_count <= 5'd16)

endmodule

bind visibility_table_merge_elect vtme_checker u_vtme_checker (.*);
